>>> rtl/core/tlqe_pkg.sv
// Shared types and constants for the thick line quad expander.
`default_nettype none
package tlqe_pkg;

    localparam int PosW     = 16;   // Q12.4 positions
    localparam int ColorW   = 32;
    localparam int LineWW   = 12;   // Q8.4 width
    localparam int ResW     = 14;
    localparam int OutW     = 16;   // Q2.14 device coordinates
    localparam int CfgIdxW  = 1;
    localparam int MagW     = 16;   // |end - start|
    localparam int SqW      = 32;
    localparam int L2W      = 33;
    localparam int RadW     = 50;   // L2 << 16, padded to an even width
    localparam int RootW    = 25;
    localparam int RootRemW = 27;
    localparam int OffQW    = 19;   // offset magnitude, Q.12
    localparam int OffNumW  = 43;
    localparam int OffW     = 20;   // signed offset
    localparam int PtW      = 25;   // corner position, Q.12
    localparam int NdcNumW  = 31;
    localparam int NdcDenW  = 15;
    localparam int NdcQW    = 17;

    localparam logic [CfgIdxW-1:0] RegScreenWidth  = 1'b0;
    localparam logic [CfgIdxW-1:0] RegScreenHeight = 1'b1;

    localparam logic [ResW-1:0] ScreenWidthRst  = 14'd1920;
    localparam logic [ResW-1:0] ScreenHeightRst = 14'd1080;

    localparam logic [1:0] SlotStartMinus = 2'd0;
    localparam logic [1:0] SlotEndMinus   = 2'd1;
    localparam logic [1:0] SlotStartPlus  = 2'd2;
    localparam logic [1:0] SlotEndPlus    = 2'd3;

    typedef struct packed {
        logic signed [PosW-1:0]   sx;
        logic signed [PosW-1:0]   sy;
        logic signed [PosW-1:0]   ex;
        logic signed [PosW-1:0]   ey;
        logic        [ColorW-1:0] color;
        logic        [LineWW-1:0] width;
    } line_t;

    typedef struct packed {
        line_t             line;
        logic              neg_x;
        logic              neg_y;
        logic [MagW-1:0]   mag_x;
        logic [MagW-1:0]   mag_y;
    } dir_t;

    typedef struct packed {
        line_t             line;
        logic              neg_x;
        logic              neg_y;
        logic [RootW-1:0]  len;
        logic [OffNumW-1:0] rem_x;
        logic [OffNumW-1:0] rem_y;
        logic [OffQW-1:0]  q_x;
        logic [OffQW-1:0]  q_y;
    } offdiv_t;

    typedef struct packed {
        line_t                 line;
        logic signed [OffW-1:0] vx;
        logic signed [OffW-1:0] vy;
    } corner_t;

    typedef struct packed {
        logic signed [PtW-1:0] px;
        logic signed [PtW-1:0] py;
        logic [ColorW-1:0]     color;
        logic [1:0]            slot;
        logic                  last;
    } vtx_t;

    typedef struct packed {
        logic [NdcNumW-1:0] rem;
        logic [NdcDenW-1:0] den;
        logic               neg;
        logic               ovf;
        logic [NdcQW-1:0]   q;
    } ndc_div_t;

    typedef struct packed {
        ndc_div_t          x;
        ndc_div_t          y;
        logic [ColorW-1:0] color;
        logic [1:0]        slot;
        logic              last;
    } ndc_t;

endpackage
`default_nettype wire

>>> rtl/core/thick_line_quad_expander.sv
// Top level of the thick line quad expander.
`default_nettype none
// Expands each 2D line transaction (Q12.4 end points, RGBA color, Q8.4 width) into
// four vertex transactions in device coordinates (Q2.14, y flipped, saturated):
// start minus, end minus, start plus, end plus, with last set on the fourth.
// Lines shorter than half a pixel produce no vertices. A new line may enter on
// every cycle until the pipeline fills; after that a line enters only as the
// corner sequencer and the output channel, which move one vertex per cycle
// while the output does not stall, issue the last corner of the held line.
// The path holds 29 stages for length and square root, 20 for the offset division,
// one in the sequencer and 20 for the device coordinate division and output
// register. in_stall rises whenever the output is stalled or the sequencer
// still has corners of the held line to issue; the whole line pipeline then
// holds. Write screen_width (index 0) and screen_height (index 1) only while
// the block is idle; a value of 0 acts as 1.
module thick_line_quad_expander (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write port
    input  wire logic                              cfg_write,
    input  wire logic [tlqe_pkg::CfgIdxW-1:0]      cfg_index,
    input  wire logic [tlqe_pkg::ResW-1:0]         cfg_data,
    // line channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [tlqe_pkg::PosW-1:0]  start_x,
    input  wire logic signed [tlqe_pkg::PosW-1:0]  start_y,
    input  wire logic signed [tlqe_pkg::PosW-1:0]  end_x,
    input  wire logic signed [tlqe_pkg::PosW-1:0]  end_y,
    input  wire logic [tlqe_pkg::ColorW-1:0]       line_color,
    input  wire logic [tlqe_pkg::LineWW-1:0]       line_width,
    // vertex channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [tlqe_pkg::OutW-1:0]       vertex_x,
    output logic signed [tlqe_pkg::OutW-1:0]       vertex_y,
    output logic [tlqe_pkg::ColorW-1:0]            vertex_color,
    output logic [1:0]                             vertex_slot,
    output logic                                   last
);

    logic [tlqe_pkg::ResW-1:0] screen_width_reg;
    logic [tlqe_pkg::ResW-1:0] screen_height_reg;

    tlqe_pkg::line_t   in_line;
    logic              len_valid;
    tlqe_pkg::dir_t    len_dir;
    logic [tlqe_pkg::RootW-1:0] len_len;
    logic              off_valid;
    tlqe_pkg::corner_t off_corner;
    logic              seq_ready;
    logic              seq_valid;
    tlqe_pkg::vtx_t    seq_vtx;

    // vtx_adv: the vertex stages move whenever the output register is free or
    // being taken. line_adv additionally waits for the sequencer to take a line.
    logic vtx_adv;
    logic line_adv;

    assign vtx_adv  = !(out_valid && out_stall);
    assign line_adv = vtx_adv && seq_ready;
    assign in_stall = !line_adv;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= tlqe_pkg::ScreenWidthRst;
            screen_height_reg <= tlqe_pkg::ScreenHeightRst;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tlqe_pkg::RegScreenWidth:  screen_width_reg  <= cfg_data;
                tlqe_pkg::RegScreenHeight: screen_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        in_line.sx    = start_x;
        in_line.sy    = start_y;
        in_line.ex    = end_x;
        in_line.ey    = end_y;
        in_line.color = line_color;
        in_line.width = line_width;
    end

    // Direction, squared length, short-line drop and square root
    tlqe_len_pipe u_len (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (line_adv),
        .in_valid  (in_valid),
        .in_line   (in_line),
        .out_valid (len_valid),
        .out_dir   (len_dir),
        .out_len   (len_len)
    );

    // Direction scaled to half the width
    tlqe_offset_pipe u_offset (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (line_adv),
        .in_valid   (len_valid),
        .in_dir     (len_dir),
        .in_len     (len_len),
        .out_valid  (off_valid),
        .out_corner (off_corner)
    );

    // Hold a line and issue its four corners
    tlqe_corner_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (vtx_adv),
        .in_valid  (off_valid),
        .in_corner (off_corner),
        .ready     (seq_ready),
        .out_valid (seq_valid),
        .out_vtx   (seq_vtx)
    );

    // Map each corner to device coordinates; ends in the output register
    tlqe_ndc_pipe u_ndc (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (vtx_adv),
        .in_valid  (seq_valid),
        .in_vtx    (seq_vtx),
        .res_x     (screen_width_reg),
        .res_y     (screen_height_reg),
        .out_valid (out_valid),
        .out_x     (vertex_x),
        .out_y     (vertex_y),
        .out_color (vertex_color),
        .out_slot  (vertex_slot),
        .out_last  (last)
    );

endmodule
`default_nettype wire

>>> rtl/core/tlqe_len_pipe.sv
// Line length pipeline: direction, squared length and digit-serial square root.
`default_nettype none
module tlqe_len_pipe (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         adv,
    input  wire logic                         in_valid,
    input  wire tlqe_pkg::line_t              in_line,
    output logic                              out_valid,
    output tlqe_pkg::dir_t                    out_dir,
    output logic [tlqe_pkg::RootW-1:0]        out_len
);

    typedef struct packed {
        tlqe_pkg::dir_t                  dir;
        logic [tlqe_pkg::RadW-1:0]       n;
        logic [tlqe_pkg::RootW-1:0]      root;
        logic [tlqe_pkg::RootRemW-1:0]   rem;
    } sqrt_t;

    tlqe_pkg::line_t line_reg;
    logic            v1_reg;
    tlqe_pkg::dir_t  dir_reg;
    tlqe_pkg::dir_t  dir_next;
    logic            v2_reg;
    tlqe_pkg::dir_t  dir3_reg;
    logic [tlqe_pkg::SqW-1:0] sq_x_reg;
    logic [tlqe_pkg::SqW-1:0] sq_y_reg;
    logic            v3_reg;
    logic [tlqe_pkg::L2W-1:0] l2;
    logic signed [tlqe_pkg::PosW:0] dx;
    logic signed [tlqe_pkg::PosW:0] dy;

    sqrt_t root_reg [0:tlqe_pkg::RootW];
    logic  rv_reg   [0:tlqe_pkg::RootW];

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_comb
    begin
        dx = {line_reg.ex[tlqe_pkg::PosW-1], line_reg.ex}
           - {line_reg.sx[tlqe_pkg::PosW-1], line_reg.sx};
        dy = {line_reg.ey[tlqe_pkg::PosW-1], line_reg.ey}
           - {line_reg.sy[tlqe_pkg::PosW-1], line_reg.sy};
        dir_next.line  = line_reg;
        dir_next.neg_x = dx[tlqe_pkg::PosW];
        dir_next.neg_y = dy[tlqe_pkg::PosW];
        dir_next.mag_x = dx[tlqe_pkg::PosW] ? tlqe_pkg::MagW'(-dx) : dx[tlqe_pkg::MagW-1:0];
        dir_next.mag_y = dy[tlqe_pkg::PosW] ? tlqe_pkg::MagW'(-dy) : dy[tlqe_pkg::MagW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            line_reg <= in_line;
            dir_reg  <= dir_next;
            dir3_reg <= dir_reg;
            sq_x_reg <= dir_reg.mag_x * dir_reg.mag_x;
            sq_y_reg <= dir_reg.mag_y * dir_reg.mag_y;
        end
    end

    assign l2 = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};

    // drop lines shorter than half a pixel (L2 below 64 in Q.8)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            rv_reg[0] <= v3_reg && (l2 >= tlqe_pkg::L2W'(64));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            root_reg[0].dir  <= dir3_reg;
            root_reg[0].n    <= {1'b0, l2, 16'b0};
            root_reg[0].root <= '0;
            root_reg[0].rem  <= '0;
        end
    end

    // one result bit per stage
    for (genvar i = 0; i < tlqe_pkg::RootW; i++)
    begin : g_root
        logic [tlqe_pkg::RootRemW-1:0] rem_w;
        logic [tlqe_pkg::RootRemW-1:0] trial;
        logic                          ge;
        sqrt_t                         root_next;

        always_comb
        begin
            rem_w = {root_reg[i].rem[tlqe_pkg::RootW-1:0],
                     root_reg[i].n[tlqe_pkg::RadW-1 -: 2]};
            trial = {root_reg[i].root, 2'b01};
            ge    = rem_w >= trial;
            root_next      = root_reg[i];
            root_next.n    = {root_reg[i].n[tlqe_pkg::RadW-3:0], 2'b00};
            root_next.root = {root_reg[i].root[tlqe_pkg::RootW-2:0], ge};
            root_next.rem  = ge ? rem_w - trial : rem_w;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rv_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                rv_reg[i+1] <= rv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                root_reg[i+1] <= root_next;
            end
        end
    end

    assign out_valid = rv_reg[tlqe_pkg::RootW];
    assign out_dir   = root_reg[tlqe_pkg::RootW].dir;
    assign out_len   = root_reg[tlqe_pkg::RootW].root;

endmodule
`default_nettype wire

>>> rtl/core/tlqe_offset_pipe.sv
// Offset pipeline: half-width perpendicular offset by restoring division.
`default_nettype none
module tlqe_offset_pipe (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  adv,
    input  wire logic                  in_valid,
    input  wire tlqe_pkg::dir_t        in_dir,
    input  wire logic [tlqe_pkg::RootW-1:0] in_len,
    output logic                       out_valid,
    output tlqe_pkg::corner_t          out_corner
);

    tlqe_pkg::offdiv_t div_reg [0:tlqe_pkg::OffQW];
    logic              dv_reg  [0:tlqe_pkg::OffQW];
    logic [tlqe_pkg::OffNumW-15-1:0] prod_x;
    logic [tlqe_pkg::OffNumW-15-1:0] prod_y;
    tlqe_pkg::offdiv_t last_div;

    assign prod_x = in_dir.mag_x * in_dir.line.width;
    assign prod_y = in_dir.mag_y * in_dir.line.width;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_reg[0] <= in_valid;
        end
    end

    // dividend is |d| * w * 2^15
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_reg[0].line  <= in_dir.line;
            div_reg[0].neg_x <= in_dir.neg_x;
            div_reg[0].neg_y <= in_dir.neg_y;
            div_reg[0].len   <= in_len;
            div_reg[0].rem_x <= {prod_x, 15'b0};
            div_reg[0].rem_y <= {prod_y, 15'b0};
            div_reg[0].q_x   <= '0;
            div_reg[0].q_y   <= '0;
        end
    end

    for (genvar i = 0; i < tlqe_pkg::OffQW; i++)
    begin : g_div
        localparam int Bit = tlqe_pkg::OffQW - 1 - i;
        logic [tlqe_pkg::OffNumW-1:0] dsh;
        logic                         ge_x;
        logic                         ge_y;
        tlqe_pkg::offdiv_t            div_next;

        always_comb
        begin
            dsh  = tlqe_pkg::OffNumW'(div_reg[i].len) << Bit;
            ge_x = div_reg[i].rem_x >= dsh;
            ge_y = div_reg[i].rem_y >= dsh;
            div_next       = div_reg[i];
            div_next.rem_x = ge_x ? div_reg[i].rem_x - dsh : div_reg[i].rem_x;
            div_next.rem_y = ge_y ? div_reg[i].rem_y - dsh : div_reg[i].rem_y;
            div_next.q_x   = {div_reg[i].q_x[tlqe_pkg::OffQW-2:0], ge_x};
            div_next.q_y   = {div_reg[i].q_y[tlqe_pkg::OffQW-2:0], ge_y};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_reg[i+1] <= dv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_reg[i+1] <= div_next;
            end
        end
    end

    // restore the sign: truncation toward zero
    always_comb
    begin
        last_div        = div_reg[tlqe_pkg::OffQW];
        out_corner.line = last_div.line;
        out_corner.vx   = last_div.neg_x ? -{1'b0, last_div.q_x} : {1'b0, last_div.q_x};
        out_corner.vy   = last_div.neg_y ? -{1'b0, last_div.q_y} : {1'b0, last_div.q_y};
    end

    assign out_valid = dv_reg[tlqe_pkg::OffQW];

endmodule
`default_nettype wire

>>> rtl/core/tlqe_corner_seq.sv
// Corner sequencer: holds one line and issues its four corners, one per cycle while not stalled.
`default_nettype none
module tlqe_corner_seq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire tlqe_pkg::corner_t in_corner,
    output logic                   ready,
    output logic                   out_valid,
    output tlqe_pkg::vtx_t         out_vtx
);

    tlqe_pkg::corner_t cur_reg;
    logic              busy_reg;
    logic [1:0]        slot_reg;
    logic signed [tlqe_pkg::PosW-1:0] bx;
    logic signed [tlqe_pkg::PosW-1:0] by;
    logic signed [tlqe_pkg::PtW-1:0]  ox;
    logic signed [tlqe_pkg::PtW-1:0]  oy;
    logic                             at_end;
    logic                             plus_side;

    assign ready = !busy_reg || (slot_reg == tlqe_pkg::SlotEndPlus);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            slot_reg <= tlqe_pkg::SlotStartMinus;
        end
        else if (adv)
        begin
            if (ready)
            begin
                busy_reg <= in_valid;
                slot_reg <= tlqe_pkg::SlotStartMinus;
            end
            else
            begin
                slot_reg <= slot_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && ready)
        begin
            cur_reg <= in_corner;
        end
    end

    // odd slots use the end point, upper slots the plus side
    always_comb
    begin
        at_end    = slot_reg inside {tlqe_pkg::SlotEndMinus, tlqe_pkg::SlotEndPlus};
        plus_side = slot_reg inside {tlqe_pkg::SlotStartPlus, tlqe_pkg::SlotEndPlus};
        bx = at_end ? cur_reg.line.ex : cur_reg.line.sx;
        by = at_end ? cur_reg.line.ey : cur_reg.line.sy;
        ox = {{(tlqe_pkg::PtW-tlqe_pkg::OffW){cur_reg.vy[tlqe_pkg::OffW-1]}}, cur_reg.vy};
        oy = {{(tlqe_pkg::PtW-tlqe_pkg::OffW){cur_reg.vx[tlqe_pkg::OffW-1]}}, cur_reg.vx};
        out_vtx.px    = {bx[tlqe_pkg::PosW-1], bx, 8'b0} + (plus_side ? -ox : ox);
        out_vtx.py    = {by[tlqe_pkg::PosW-1], by, 8'b0} + (plus_side ? oy : -oy);
        out_vtx.color = cur_reg.line.color;
        out_vtx.slot  = slot_reg;
        out_vtx.last  = (slot_reg == tlqe_pkg::SlotEndPlus);
    end

    assign out_valid = busy_reg;

endmodule
`default_nettype wire

>>> rtl/core/tlqe_ndc_pipe.sv
// Device coordinate pipeline: rounded division by resolution, flip and saturate.
`default_nettype none
module tlqe_ndc_pipe (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        adv,
    input  wire logic                        in_valid,
    input  wire tlqe_pkg::vtx_t              in_vtx,
    input  wire logic [tlqe_pkg::ResW-1:0]   res_x,
    input  wire logic [tlqe_pkg::ResW-1:0]   res_y,
    output logic                             out_valid,
    output logic signed [tlqe_pkg::OutW-1:0] out_x,
    output logic signed [tlqe_pkg::OutW-1:0] out_y,
    output logic [tlqe_pkg::ColorW-1:0]      out_color,
    output logic [1:0]                       out_slot,
    output logic                             out_last
);

    localparam int Steps = tlqe_pkg::NdcQW;

    tlqe_pkg::vtx_t vtx_reg;
    logic           vv_reg;
    tlqe_pkg::ndc_t ndc_reg [0:Steps];
    logic           nv_reg  [0:Steps];
    tlqe_pkg::ndc_t ndc_first;
    logic signed [tlqe_pkg::OutW-1:0] x_next;
    logic signed [tlqe_pkg::OutW-1:0] y_next;
    logic                             out_valid_reg;

    // floor((16p + R) / 2R) as a magnitude division plus sign
    function automatic tlqe_pkg::ndc_div_t ndc_prep(
        input logic signed [tlqe_pkg::PtW-1:0] p,
        input logic [tlqe_pkg::ResW-1:0]       res
    );
        logic [tlqe_pkg::ResW-1:0]           r;
        logic signed [tlqe_pkg::NdcNumW-1:0] num;
        logic [tlqe_pkg::NdcDenW-1:0]        den;
        logic [tlqe_pkg::NdcNumW-1:0]        mag;
        tlqe_pkg::ndc_div_t                  d;
        r   = (res == '0) ? tlqe_pkg::ResW'(1) : res;
        den = {r, 1'b0};
        num = {{2{p[tlqe_pkg::PtW-1]}}, p, 4'b0} + tlqe_pkg::NdcNumW'(r);
        if (num[tlqe_pkg::NdcNumW-1])
        begin
            mag = tlqe_pkg::NdcNumW'(-num) + tlqe_pkg::NdcNumW'(den) - tlqe_pkg::NdcNumW'(1);
        end
        else
        begin
            mag = num;
        end
        d.rem = mag;
        d.den = den;
        d.neg = num[tlqe_pkg::NdcNumW-1];
        d.ovf = {1'b0, mag} >= {den, {tlqe_pkg::NdcQW{1'b0}}};
        d.q   = '0;
        return d;
    endfunction

    function automatic tlqe_pkg::ndc_div_t ndc_step(
        input tlqe_pkg::ndc_div_t d,
        input int                 bit_pos
    );
        logic [tlqe_pkg::NdcNumW-1:0] dsh;
        logic                         ge;
        tlqe_pkg::ndc_div_t           n;
        dsh   = tlqe_pkg::NdcNumW'(d.den) << bit_pos;
        ge    = d.rem >= dsh;
        n     = d;
        n.rem = ge ? d.rem - dsh : d.rem;
        n.q   = {d.q[tlqe_pkg::NdcQW-2:0], ge};
        return n;
    endfunction

    // signed quotient, clamped to full scale on overflow
    function automatic logic signed [tlqe_pkg::NdcQW+1:0] ndc_quot(
        input tlqe_pkg::ndc_div_t d
    );
        logic [tlqe_pkg::NdcQW-1:0]          qs;
        logic signed [tlqe_pkg::NdcQW+1:0]   qv;
        qs = d.ovf ? '1 : d.q;
        qv = {2'b00, qs};
        return d.neg ? -qv : qv;
    endfunction

    function automatic logic signed [tlqe_pkg::OutW-1:0] sat16(
        input logic signed [tlqe_pkg::NdcQW+1:0] v
    );
        logic signed [tlqe_pkg::OutW-1:0] s;
        if (v > (tlqe_pkg::NdcQW+2)'(32767))
        begin
            s = 16'sh7FFF;
        end
        else if (v < -(tlqe_pkg::NdcQW+2)'(32768))
        begin
            s = 16'sh8000;
        end
        else
        begin
            s = v[tlqe_pkg::OutW-1:0];
        end
        return s;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vv_reg    <= 1'b0;
            nv_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vv_reg    <= in_valid;
            nv_reg[0] <= vv_reg;
        end
    end

    always_comb
    begin
        ndc_first.x     = ndc_prep(vtx_reg.px, res_x);
        ndc_first.y     = ndc_prep(vtx_reg.py, res_y);
        ndc_first.color = vtx_reg.color;
        ndc_first.slot  = vtx_reg.slot;
        ndc_first.last  = vtx_reg.last;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vtx_reg    <= in_vtx;
            ndc_reg[0] <= ndc_first;
        end
    end

    for (genvar i = 0; i < Steps; i++)
    begin : g_div
        tlqe_pkg::ndc_t ndc_next;

        always_comb
        begin
            ndc_next   = ndc_reg[i];
            ndc_next.x = ndc_step(ndc_reg[i].x, Steps - 1 - i);
            ndc_next.y = ndc_step(ndc_reg[i].y, Steps - 1 - i);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                nv_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                nv_reg[i+1] <= nv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ndc_reg[i+1] <= ndc_next;
            end
        end
    end

    // x maps to q - 1.0, y flips to 1.0 - q
    always_comb
    begin
        x_next = sat16(ndc_quot(ndc_reg[Steps].x) - (tlqe_pkg::NdcQW+2)'(16384));
        y_next = sat16((tlqe_pkg::NdcQW+2)'(16384) - ndc_quot(ndc_reg[Steps].y));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= nv_reg[Steps];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_x     <= x_next;
            out_y     <= y_next;
            out_color <= ndc_reg[Steps].color;
            out_slot  <= ndc_reg[Steps].slot;
            out_last  <= ndc_reg[Steps].last;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire
